FILE: rtl/clock_follower_and_generator_defines.svh
// ----------------------------------------------------------------------------
// Clock follower and generator: assertion macros
// Shared concurrent assertion forms for the clock follower design.
// ----------------------------------------------------------------------------
`ifndef CLOCK_FOLLOWER_AND_GENERATOR_DEFINES_SVH
`define CLOCK_FOLLOWER_AND_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFAG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("clock follower assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CFAG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("clock follower assertion failed");

`endif

FILE: rtl/cfag_pkg.sv
// ----------------------------------------------------------------------------
// Clock follower package
// Shared types, register indexes and reset values of the clock follower.
// ----------------------------------------------------------------------------
`default_nettype none

package cfag_pkg;

	localparam int COUNT_BITS_DEFAULT = 20;
	localparam int RING_DEPTH         = 4;
	localparam int RING_BITS          = $clog2(RING_DEPTH);
	localparam int SCALE_BITS         = 6;

	localparam int PERIOD_W    = 16;
	localparam int FACTOR_W    = 4;
	localparam int LEVEL_W     = 10;
	localparam int TIMEOUT_W   = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int BASE_OUT_W  = 20;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 24;

	localparam logic [PERIOD_W-1:0]  PERIOD_RESET    = 16'd500;
	localparam logic [FACTOR_W-1:0]  FACTOR_RESET    = 4'd6;
	localparam logic [LEVEL_W-1:0]   THRESHOLD_RESET = 10'd620;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd3000;

	localparam logic [FACTOR_W-1:0] FACTOR_UNITY = 4'd6;
	localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 4'd12;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_INTERNAL_PERIOD = 2'd0,
		REG_FACTOR_SELECT   = 2'd1,
		REG_LEVEL_THRESHOLD = 2'd2,
		REG_TIMEOUT         = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [PERIOD_W-1:0]  internal_period;
		logic [FACTOR_W-1:0]  factor_select;
		logic [LEVEL_W-1:0]   level_threshold;
		logic [TIMEOUT_W-1:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic [BASE_OUT_W-1:0] base_period_ms;
		logic                  external_mode;
		logic                  gate_out;
		logic                  tick;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/clock_follower_and_generator.sv
// ----------------------------------------------------------------------------
// Clock follower and generator
// Follows an external clock sampled once per millisecond, averages its
// period, and generates scaled ticks and a gate from it or an internal period.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  s_*      | in        | one millisecond sample per request
//  m_*      | out       | tick, gate, mode and base period per sample
//  cfg_*    | in        | register writes, no read-back
//
// A request is taken every cycle while s_tready is high; its result passes through
// the input register and then the result register before it leaves.
// The whole millisecond step is computed between those two registers.
// A stalled result register holds, and one more request waits in the input
// register before s_tready falls.
// Reset is asynchronous and clears the control and core state to its power-up values;
// the sample and result data registers are not reset.
`default_nettype none

`include "clock_follower_and_generator_defines.svh"

module clock_follower_and_generator #(
	parameter int COUNT_BITS = cfag_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	// clock_sample [9:0], zero fill [15:10]
	input  wire logic [cfag_pkg::IN_DATA_W-1:0]     s_tdata,
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	// tick [0], gate_out [1], external_mode [2], base_period_ms [22:3], zero [23]
	output      logic [cfag_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [cfag_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [cfag_pkg::CFG_DATA_W-1:0]    cfg_data
);

	cfag_pkg::cfg_t                   cfg;
	cfag_pkg::result_t                result;

	logic                             valid_s1;
	logic [cfag_pkg::LEVEL_W-1:0]     sample_s1;
	logic                             out_valid_q;
	cfag_pkg::result_t                out_q;
	logic                             out_load;
	logic                             advance;

	assign out_load = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_load;
	assign s_tready = !valid_s1 || out_load;

	cfag_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cfag_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.sample (sample_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_load) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata[cfag_pkg::LEVEL_W-1:0];
		end
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = cfag_pkg::OUT_DATA_W'(out_q);

	`CFAG_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(sample_s1))
	`CFAG_ASSERT_NEXT(a_advance_shows, clk, arst_n, advance, out_valid_q)

endmodule

`default_nettype wire

FILE: rtl/cfag_cfg_regs.sv
// ----------------------------------------------------------------------------
// Clock follower configuration registers
// Decodes register writes and holds the four settings of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module cfag_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [cfag_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [cfag_pkg::CFG_DATA_W-1:0]    cfg_data,
	output cfag_pkg::cfg_t                          cfg
);

	cfag_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.internal_period <= cfag_pkg::PERIOD_RESET;
			cfg_q.factor_select   <= cfag_pkg::FACTOR_RESET;
			cfg_q.level_threshold <= cfag_pkg::THRESHOLD_RESET;
			cfg_q.timeout         <= cfag_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfag_pkg::reg_index_t'(cfg_index))
				cfag_pkg::REG_INTERNAL_PERIOD: begin
					cfg_q.internal_period <= cfg_data[cfag_pkg::PERIOD_W-1:0];
				end
				cfag_pkg::REG_FACTOR_SELECT: begin
					cfg_q.factor_select <= cfg_data[cfag_pkg::FACTOR_W-1:0];
				end
				cfag_pkg::REG_LEVEL_THRESHOLD: begin
					cfg_q.level_threshold <= cfg_data[cfag_pkg::LEVEL_W-1:0];
				end
				cfag_pkg::REG_TIMEOUT: begin
					cfg_q.timeout <= cfg_data[cfag_pkg::TIMEOUT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/cfag_core.sv
// ----------------------------------------------------------------------------
// Clock follower core
// Holds the follower state and computes one millisecond step per request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clock_follower_and_generator_defines.svh"

module cfag_core #(
	parameter int COUNT_BITS = cfag_pkg::COUNT_BITS_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic [cfag_pkg::LEVEL_W-1:0]   sample,
	input  wire cfag_pkg::cfg_t                 cfg,
	output cfag_pkg::result_t                   result
);

	localparam int TICK_W = COUNT_BITS + cfag_pkg::SCALE_BITS;
	localparam int FIVE_W = TICK_W + 3;
	localparam int SUM_W  = COUNT_BITS + cfag_pkg::RING_BITS;
	localparam int WIDE_W = (COUNT_BITS > cfag_pkg::BASE_OUT_W) ?
		COUNT_BITS : cfag_pkg::BASE_OUT_W;

	logic                              prev_level_q;
	logic [COUNT_BITS-1:0]             since_edge_q;
	logic [COUNT_BITS-1:0]             uptime_q;
	logic [COUNT_BITS-1:0]             ring_q [cfag_pkg::RING_DEPTH];
	logic [cfag_pkg::RING_BITS-1:0]    slot_q;
	logic [SUM_W-1:0]                  sum_q;
	logic [COUNT_BITS-1:0]             avg_q;
	logic                              external_q;
	logic [TICK_W-1:0]                 since_tick_q;
	logic                              gate_q;

	logic                              level;
	logic                              rise;
	logic [COUNT_BITS-1:0]             uptime_inc;
	logic [COUNT_BITS-1:0]             since_edge_inc;
	logic [COUNT_BITS-1:0]             since_edge_new;
	logic [TICK_W-1:0]                 since_tick_inc;
	logic [TICK_W-1:0]                 since_tick_new;
	logic [SUM_W-1:0]                  sum_new;
	logic [COUNT_BITS-1:0]             avg_new;
	logic                              external_new;
	logic [COUNT_BITS-1:0]             base;
	logic [WIDE_W-1:0]                 base_wide;
	logic [cfag_pkg::FACTOR_W-1:0]     factor;
	logic [TICK_W-1:0]                 scaled;
	logic                              tick;
	logic [FIVE_W-1:0]                 five_times;
	logic                              gate_new;

	always_comb begin
		level = sample > cfg.level_threshold;
		rise  = !prev_level_q && level;

		uptime_inc     = (uptime_q == '1) ? uptime_q : uptime_q + 1'b1;
		since_edge_inc = (since_edge_q == '1) ? since_edge_q : since_edge_q + 1'b1;
		since_tick_inc = (since_tick_q == '1) ? since_tick_q : since_tick_q + 1'b1;

		// The running sum swaps the oldest interval for the new one.
		sum_new = sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(since_edge_inc);
		avg_new = rise ? sum_new[SUM_W-1:cfag_pkg::RING_BITS] : avg_q;
		since_edge_new = rise ? '0 : since_edge_inc;

		priority if (since_edge_new > COUNT_BITS'(cfg.timeout)) begin
			external_new = 1'b0;
		end else if (uptime_inc > COUNT_BITS'(cfg.timeout)) begin
			external_new = 1'b1;
		end else begin
			external_new = external_q;
		end

		base   = external_new ? avg_new : COUNT_BITS'(cfg.internal_period);
		factor = (cfg.factor_select > cfag_pkg::FACTOR_MAX) ?
			cfag_pkg::FACTOR_MAX : cfg.factor_select;
		if (factor <= cfag_pkg::FACTOR_UNITY) begin
			scaled = TICK_W'(base) << (cfag_pkg::FACTOR_UNITY - factor);
		end else begin
			scaled = TICK_W'(base) >> (factor - cfag_pkg::FACTOR_UNITY);
		end

		tick           = since_tick_inc >= scaled;
		since_tick_new = tick ? '0 : since_tick_inc;

		five_times = FIVE_W'({since_tick_new, 2'b00}) + FIVE_W'(since_tick_new);
		gate_new   = external_new ? gate_q : !(five_times >= FIVE_W'(scaled));

		base_wide = WIDE_W'(base);
		result.tick           = tick;
		result.gate_out       = gate_new;
		result.external_mode  = external_new;
		result.base_period_ms = base_wide[cfag_pkg::BASE_OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			since_edge_q <= '0;
			uptime_q     <= '0;
			for (int i = 0; i < cfag_pkg::RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			slot_q       <= '0;
			sum_q        <= '0;
			avg_q        <= '0;
			external_q   <= 1'b0;
			since_tick_q <= '0;
			gate_q       <= 1'b0;
		end else if (step) begin
			prev_level_q <= level;
			since_edge_q <= since_edge_new;
			uptime_q     <= uptime_inc;
			if (rise) begin
				ring_q[slot_q] <= since_edge_inc;
				slot_q         <= (slot_q == cfag_pkg::RING_BITS'(cfag_pkg::RING_DEPTH - 1)) ?
					'0 : slot_q + 1'b1;
				sum_q          <= sum_new;
			end
			avg_q        <= avg_new;
			external_q   <= external_new;
			since_tick_q <= since_tick_new;
			gate_q       <= gate_new;
		end
	end

	`CFAG_ASSERT_NEXT(a_tick_clears, clk, arst_n, step && tick, since_tick_q == '0)
	`CFAG_ASSERT_NEXT(a_rise_clears, clk, arst_n, step && rise, since_edge_q == '0)
	`CFAG_ASSERT_SAME(a_edge_le_up, clk, arst_n, 1'b1, since_edge_q <= uptime_q)

endmodule

`default_nettype wire
